// ===== hw/rtl/cff_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// CFF DICT token decoder package
// Shared beat types, token kind codes, parser phases and result queue sizing.
// ----------------------------------------------------------------------------
package cff_tok_pkg;

   localparam int QDepth = 4;
   localparam int QAddrW = $clog2(QDepth);
   localparam int QCountW = $clog2(QDepth + 1);

   localparam logic [2:0] KIND_INT   = 3'd0;
   localparam logic [2:0] KIND_OP    = 3'd1;
   localparam logic [2:0] KIND_NIB   = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_BAD   = 3'd4;
   localparam logic [2:0] KIND_RSV   = 3'd5;
   localparam logic [2:0] KIND_TRUNC = 3'd6;

   localparam logic [7:0] BYTE_ESCAPE    = 8'd12;
   localparam logic [7:0] BYTE_OP_MAX    = 8'd21;
   localparam logic [7:0] BYTE_SHORTINT  = 8'd28;
   localparam logic [7:0] BYTE_LONGINT   = 8'd29;
   localparam logic [7:0] BYTE_REAL      = 8'd30;
   localparam logic [7:0] BYTE_SMALL_MIN = 8'd32;
   localparam logic [7:0] BYTE_SMALL_MAX = 8'd246;
   localparam logic [7:0] BYTE_POS_MIN   = 8'd247;
   localparam logic [7:0] BYTE_POS_MAX   = 8'd250;
   localparam logic [7:0] BYTE_NEG_MIN   = 8'd251;
   localparam logic [7:0] BYTE_NEG_MAX   = 8'd254;
   localparam logic [7:0] SMALL_BIAS     = 8'd139;
   localparam logic [31:0] TWO_BYTE_BIAS = 32'd108;

   localparam logic [3:0] NIB_END = 4'hf;
   localparam logic [3:0] NIB_RSV = 4'hd;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_INT,
      PH_ESC,
      PH_REAL
   } phase_type;

   typedef struct packed {
      logic [7:0] dict_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]         token_kind;
      logic signed [31:0] token_value;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } dec_out_type;

endpackage

// ===== hw/rtl/cff_tok_decode.sv =====
// ----------------------------------------------------------------------------
// CFF DICT token decoder - byte decoder
// Holds the parser state and turns one dict byte into zero to two tokens.
// ----------------------------------------------------------------------------
module cff_tok_decode
   import cff_tok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   output dec_out_type dec_out
);

   phase_type   phase_ff, phase_in, phase_mid;
   logic [2:0]  pend_ff, pend_in;
   logic [7:0]  lead_ff, lead_in;
   logic [31:0] acc_ff, acc_in;

   logic [7:0]  b;
   logic [3:0]  nib_hi, nib_lo;
   logic        lead_pos, lead_neg, real_done;
   logic [7:0]  ext_pos, ext_neg;
   logic [31:0] pos_val, neg_val, acc_shift;
   logic [2:0]  pend_dec;
   dec_out_type res;

   assign b         = req_data.dict_byte;
   assign nib_hi    = b[7:4];
   assign nib_lo    = b[3:0];
   assign lead_pos  = (lead_ff >= BYTE_POS_MIN) && (lead_ff <= BYTE_POS_MAX);
   assign lead_neg  = (lead_ff >= BYTE_NEG_MIN) && (lead_ff <= BYTE_NEG_MAX);
   assign ext_pos   = lead_ff - BYTE_POS_MIN;
   assign ext_neg   = lead_ff - BYTE_NEG_MIN;
   assign pos_val   = {22'd0, ext_pos[1:0], b} + TWO_BYTE_BIAS;
   assign neg_val   = 32'd0 - ({22'd0, ext_neg[1:0], b} + TWO_BYTE_BIAS);
   assign acc_shift = {acc_ff[23:0], b};
   assign pend_dec  = pend_ff - 3'd1;
   assign real_done = (nib_hi == NIB_END) || (nib_hi == NIB_RSV) ||
                      (nib_lo == NIB_END) || (nib_lo == NIB_RSV);

   always_comb begin
      phase_mid = phase_ff;
      pend_in   = pend_ff;
      lead_in   = lead_ff;
      acc_in    = acc_ff;
      case (phase_ff)
         PH_IDLE: begin
            lead_in = b;
            if (b == BYTE_ESCAPE) begin
               phase_mid = PH_ESC;
            end else if (b <= BYTE_OP_MAX) begin
               phase_mid = PH_IDLE;
            end else if ((b >= BYTE_SMALL_MIN) && (b <= BYTE_SMALL_MAX)) begin
               phase_mid = PH_IDLE;
            end else if ((b >= BYTE_POS_MIN) && (b <= BYTE_NEG_MAX)) begin
               phase_mid = PH_INT;
               pend_in   = 3'd1;
            end else if (b == BYTE_SHORTINT) begin
               phase_mid = PH_INT;
               pend_in   = 3'd2;
               acc_in    = 32'd0;
            end else if (b == BYTE_LONGINT) begin
               phase_mid = PH_INT;
               pend_in   = 3'd4;
               acc_in    = 32'd0;
            end else if (b == BYTE_REAL) begin
               phase_mid = PH_REAL;
            end
         end
         PH_ESC: begin
            phase_mid = PH_IDLE;
            pend_in   = 3'd0;
            acc_in    = 32'd0;
         end
         PH_INT: begin
            if (lead_pos || lead_neg || (pend_dec == 3'd0)) begin
               phase_mid = PH_IDLE;
               pend_in   = 3'd0;
               acc_in    = 32'd0;
            end else begin
               acc_in  = acc_shift;
               pend_in = pend_dec;
            end
         end
         PH_REAL: begin
            if (real_done) begin
               phase_mid = PH_IDLE;
               pend_in   = 3'd0;
               acc_in    = 32'd0;
            end
         end
         default: begin
            phase_mid = PH_IDLE;
            pend_in   = 3'd0;
            acc_in    = 32'd0;
         end
      endcase
      phase_in = phase_mid;
      if (req_data.last_byte) begin
         phase_in = PH_IDLE;
         pend_in  = 3'd0;
         acc_in   = 32'd0;
      end
   end

   always_comb begin
      res            = '0;
      res.res0.token_kind = KIND_INT;
      res.res1.token_kind = KIND_INT;
      case (phase_ff)
         PH_IDLE: begin
            if (b == BYTE_ESCAPE) begin
               res.count = 2'd0;
            end else if (b <= BYTE_OP_MAX) begin
               res.count            = 2'd1;
               res.res0.token_kind  = KIND_OP;
               res.res0.token_value = $signed({24'd0, b});
            end else if ((b >= BYTE_SMALL_MIN) && (b <= BYTE_SMALL_MAX)) begin
               res.count            = 2'd1;
               res.res0.token_kind  = KIND_INT;
               res.res0.token_value = $signed({24'd0, b} - {24'd0, SMALL_BIAS});
            end else if (((b >= BYTE_POS_MIN) && (b <= BYTE_NEG_MAX)) ||
                         (b == BYTE_SHORTINT) || (b == BYTE_LONGINT) ||
                         (b == BYTE_REAL)) begin
               res.count = 2'd0;
            end else begin
               res.count            = 2'd1;
               res.res0.token_kind  = KIND_BAD;
               res.res0.token_value = $signed({24'd0, b});
            end
         end
         PH_ESC: begin
            res.count            = 2'd1;
            res.res0.token_kind  = KIND_OP;
            res.res0.token_value = $signed({16'd0, BYTE_ESCAPE, b});
         end
         PH_INT: begin
            if (lead_pos) begin
               res.count            = 2'd1;
               res.res0.token_value = $signed(pos_val);
            end else if (lead_neg) begin
               res.count            = 2'd1;
               res.res0.token_value = $signed(neg_val);
            end else if (pend_dec == 3'd0) begin
               res.count = 2'd1;
               if (lead_ff == BYTE_SHORTINT) begin
                  res.res0.token_value = $signed({{16{acc_shift[15]}}, acc_shift[15:0]});
               end else begin
                  res.res0.token_value = $signed(acc_shift);
               end
            end
         end
         PH_REAL: begin
            if (nib_hi == NIB_END) begin
               res.count            = 2'd1;
               res.res0.token_kind  = KIND_END;
               res.res0.token_value = $signed({28'd0, NIB_END});
            end else if (nib_hi == NIB_RSV) begin
               res.count            = 2'd1;
               res.res0.token_kind  = KIND_RSV;
               res.res0.token_value = $signed({28'd0, NIB_RSV});
            end else begin
               res.count            = 2'd2;
               res.res0.token_kind  = KIND_NIB;
               res.res0.token_value = $signed({28'd0, nib_hi});
               if (nib_lo == NIB_END) begin
                  res.res1.token_kind  = KIND_END;
                  res.res1.token_value = $signed({28'd0, NIB_END});
               end else if (nib_lo == NIB_RSV) begin
                  res.res1.token_kind  = KIND_RSV;
                  res.res1.token_value = $signed({28'd0, NIB_RSV});
               end else begin
                  res.res1.token_kind  = KIND_NIB;
                  res.res1.token_value = $signed({28'd0, nib_lo});
               end
            end
         end
         default: begin
            res.count = 2'd0;
         end
      endcase
      if (req_data.last_byte && (phase_mid != PH_IDLE)) begin
         res.count            = 2'd1;
         res.res0.token_kind  = KIND_TRUNC;
         res.res0.token_value = $signed({24'd0, lead_in});
      end
      if (res.count == 2'd1) begin
         res.res0.last_of_run = 1'b1;
      end
      if (res.count == 2'd2) begin
         res.res1.last_of_run = 1'b1;
      end
   end

   assign dec_out = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pend_ff  <= 3'd0;
         lead_ff  <= 8'd0;
         acc_ff   <= 32'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         lead_ff  <= lead_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

// ===== hw/rtl/cff_tok_queue.sv =====
// ----------------------------------------------------------------------------
// CFF DICT token decoder - result queue
// Small token queue that takes up to two tokens per beat and hands out one.
// ----------------------------------------------------------------------------
module cff_tok_queue
   import cff_tok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  dec_out_type dec_out,
   output logic        space_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   rsp_type             entries_ff [QDepth];
   logic [QAddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCountW-1:0]  count_ff, count_in;
   logic [1:0]          push_n;
   logic                pop;
   logic [QAddrW-1:0]   wr_ptr_next;

   assign push_n      = push ? dec_out.count : 2'd0;
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + QAddrW'(1);
   assign wr_ptr_in   = wr_ptr_ff + QAddrW'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + QAddrW'(pop);
   assign count_in    = count_ff + QCountW'(push_n) - QCountW'(pop);
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = entries_ff[rd_ptr_ff];
   assign space_ok    = (count_ff <= QCountW'(QDepth - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= dec_out.res0;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_next] <= dec_out.res1;
      end
   end

endmodule

// ===== hw/rtl/cff_dict_token_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// CFF DICT token decoder
// One dict byte per beat in, integer, operator and real-nibble tokens out.
// The unit accepts one dict byte per clock whenever its four-entry token
// queue has room for two tokens. Each byte is decoded in the cycle it is
// accepted, and its tokens are written to the queue and leave in order
// through the result port. Most bytes give at most one token, so the
// sustained rate is one byte per clock while rsp_ready stays high; a byte
// in a real number whose high nibble is not the end or reserved nibble
// gives two tokens; the single result port then paces at one token per clock.
// ----------------------------------------------------------------------------
module cff_dict_token_decoder_unit
   import cff_tok_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dec_out_type dec_out;
   logic        accept;
   logic        space_ok;

   assign req_ready = space_ok;
   assign accept    = req_valid && space_ok;

   cff_tok_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .dec_out  (dec_out)
   );

   cff_tok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .dec_out   (dec_out),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/cff_tok_checker.sv =====
// ----------------------------------------------------------------------------
// CFF DICT token decoder checker
// Port-level assertions on the token output, bound to the top level.
// ----------------------------------------------------------------------------
module cff_tok_checker
   import cff_tok_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat shown right after reset.");

   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.token_kind == KIND_END) ||
                    (rsp_data.token_kind == KIND_RSV) ||
                    (rsp_data.token_kind == KIND_TRUNC)) |-> rsp_data.last_of_run)
      else $error("Terminating token is not the last of its byte.");

   a_nibble_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == KIND_NIB) |->
         (rsp_data.token_value >= 0) && (rsp_data.token_value <= 32'sd14) &&
         (rsp_data.token_value != 32'sd13))
      else $error("Real nibble token outside the plain nibble range.");

endmodule

bind cff_dict_token_decoder_unit cff_tok_checker u_checker (.*);
